FILE: src/assert_macros.svh
// Assertion helpers for the meter frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define MFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

`define MFR_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define MFR_ASSERT(lbl, clk, rstn, prop)

`define MFR_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: src/mfr_pkg.sv
`timescale 1ns / 1ps

package mfr_pkg;

  localparam logic [7:0] START_BYTE  = 8'h68;
  localparam logic [7:0] END_BYTE    = 8'h16;
  localparam logic [7:0] DATA_OFFSET = 8'h33;
  localparam logic [7:0] WILD_A      = 8'hAA;
  localparam logic [7:0] WILD_B      = 8'h99;

  localparam int unsigned ADDR_BYTES = 6;
  localparam int unsigned ADDR_W     = 8 * ADDR_BYTES;

  localparam logic [3:0] HDR_LAST_POS = 4'd8;
  localparam logic [3:0] HDR_SEP_POS  = 4'd6;
  localparam logic [3:0] HDR_CTRL_POS = 4'd7;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_length;
    logic [7:0] control_code;
    logic [7:0] data_value;
    logic [7:0] data_index;
  } result_t;

  // Bit k set: address byte k is compared (some byte at k or above is not a wildcard).
  function automatic logic [ADDR_BYTES-1:0] compare_mask(input logic [ADDR_W-1:0] addr);
    logic [ADDR_BYTES-1:0] mask;
    logic                  keep;
    logic [7:0]            b;
    mask = '0;
    keep = 1'b0;
    for (int k = ADDR_BYTES - 1; k >= 0; k--) begin
      b = addr[8*k +: 8];
      keep = keep | ((b != WILD_A) && (b != WILD_B));
      mask[k] = keep;
    end
    return mask;
  endfunction

endpackage

FILE: src/mfr_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfr_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [7:0]                       rx_byte,
  input  logic [mfr_pkg::ADDR_W-1:0]       exp_addr,
  input  logic [mfr_pkg::ADDR_BYTES-1:0]   cmp_mask,
  output logic                             has_res,
  output mfr_pkg::result_t                 res
);

  logic [1:0] phase_r, phase_nxt;
  logic [8:0] bytes_left_r, bytes_left_nxt;
  logic [3:0] hdr_pos_r, hdr_pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] flen_r, flen_nxt;
  logic [7:0] fctrl_r, fctrl_nxt;
  logic       addr_ok_r, addr_ok_nxt;
  logic       sum_ok_r, sum_ok_nxt;
  logic [7:0] dpos_r, dpos_nxt;

  logic [2:0] abyte_sel;
  logic [7:0] abyte;
  logic       addr_ok_hdr;

  assign abyte_sel = hdr_pos_r[2:0];
  assign abyte     = exp_addr[{abyte_sel, 3'b000} +: 8];

  always_comb begin
    addr_ok_hdr = addr_ok_r;
    if (hdr_pos_r < mfr_pkg::HDR_SEP_POS) begin
      if (cmp_mask[abyte_sel] && (rx_byte != abyte)) addr_ok_hdr = 1'b0;
    end else if (hdr_pos_r == mfr_pkg::HDR_SEP_POS) begin
      if (rx_byte != mfr_pkg::START_BYTE) addr_ok_hdr = 1'b0;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    hdr_pos_nxt    = hdr_pos_r;
    sum_nxt        = sum_r;
    flen_nxt       = flen_r;
    fctrl_nxt      = fctrl_r;
    addr_ok_nxt    = addr_ok_r;
    sum_ok_nxt     = sum_ok_r;
    dpos_nxt       = dpos_r;
    has_res        = 1'b0;
    res.kind         = mfr_pkg::KIND_DATA;
    res.data_index   = 8'd0;
    res.data_value   = 8'd0;
    res.control_code = fctrl_r;
    res.data_length  = flen_r;
    case (phase_r)
      mfr_pkg::PH_HEADER: begin
        sum_nxt     = sum_r + rx_byte;
        addr_ok_nxt = addr_ok_hdr;
        if (hdr_pos_r == mfr_pkg::HDR_CTRL_POS) fctrl_nxt = rx_byte;
        if (hdr_pos_r == mfr_pkg::HDR_LAST_POS) flen_nxt = rx_byte;
        hdr_pos_nxt = hdr_pos_r + 4'd1;
        if (hdr_pos_r == mfr_pkg::HDR_LAST_POS) begin
          if (addr_ok_hdr) begin
            bytes_left_nxt = {1'b0, rx_byte} + 9'd2;
            dpos_nxt       = 8'd0;
            sum_ok_nxt     = 1'b0;
            phase_nxt      = mfr_pkg::PH_BODY;
          end else begin
            phase_nxt = mfr_pkg::PH_HUNT;
          end
        end
      end
      mfr_pkg::PH_BODY: begin
        if (bytes_left_r > 9'd2) begin
          sum_nxt        = sum_r + rx_byte;
          dpos_nxt       = dpos_r + 8'd1;
          bytes_left_nxt = bytes_left_r - 9'd1;
          has_res        = 1'b1;
          res.data_index = dpos_r;
          res.data_value = rx_byte - mfr_pkg::DATA_OFFSET;
        end else if (bytes_left_r == 9'd2) begin
          sum_ok_nxt     = (rx_byte == sum_r);
          bytes_left_nxt = 9'd1;
        end else begin
          bytes_left_nxt = 9'd0;
          phase_nxt      = mfr_pkg::PH_HUNT;
          has_res        = 1'b1;
          res.kind       = (rx_byte == mfr_pkg::END_BYTE && sum_ok_r) ?
                           mfr_pkg::KIND_GOOD : mfr_pkg::KIND_BAD;
        end
      end
      default: begin
        phase_nxt = mfr_pkg::PH_HUNT;
        if (rx_byte == mfr_pkg::START_BYTE) begin
          sum_nxt     = mfr_pkg::START_BYTE;
          hdr_pos_nxt = 4'd0;
          addr_ok_nxt = 1'b1;
          phase_nxt   = mfr_pkg::PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mfr_pkg::PH_HUNT;
      bytes_left_r <= 9'd0;
      hdr_pos_r    <= 4'd0;
      sum_r        <= 8'd0;
      flen_r       <= 8'd0;
      fctrl_r      <= 8'd0;
      addr_ok_r    <= 1'b1;
      sum_ok_r     <= 1'b0;
      dpos_r       <= 8'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      sum_r        <= sum_nxt;
      flen_r       <= flen_nxt;
      fctrl_r      <= fctrl_nxt;
      addr_ok_r    <= addr_ok_nxt;
      sum_ok_r     <= sum_ok_nxt;
      dpos_r       <= dpos_nxt;
    end
  end

  `MFR_ASSERT(a_hdr_pos_range, clk, rst_n,
    (phase_r == mfr_pkg::PH_HEADER) |-> (hdr_pos_r <= mfr_pkg::HDR_LAST_POS))
  `MFR_ASSERT(a_end_returns_hunt, clk, rst_n,
    (step && phase_r == mfr_pkg::PH_BODY && bytes_left_r <= 9'd1)
      |=> (phase_r == mfr_pkg::PH_HUNT))
  `MFR_NEVER(a_body_len_bound, clk, rst_n,
    (phase_r == mfr_pkg::PH_BODY) && (bytes_left_r > 9'd257))

endmodule

FILE: src/mfr_out_stage.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mfr_pkg::result_t  res,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [1:0]        out_tuser
);

  logic             valid_r, valid_nxt;
  mfr_pkg::result_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.data_length, res_r.control_code, res_r.data_value,
                       res_r.data_index};
  assign out_tuser  = res_r.kind;

  `MFR_ASSERT(a_load_into_free_slot, clk, rst_n, load |-> (!valid_r || out_tready))

endmodule

FILE: src/meter_frame_receiver.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Meter reply frame receiver. Takes one received byte per beat and accepts a
// byte every clock cycle unless a result waits on a full output register;
// a byte passes an input register, is parsed combinationally and any result
// lands in an output register. Data bytes come out at once with 0x33
// removed (tuser = data); the end byte yields a good or bad frame status.
// Frames whose header or address does not match are dropped with no result.
// Trailing 0xAA/0x99 bytes of the configured address act as wildcards.
// Write the address register only while no frame is in progress.
module meter_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [7:0] data_index, [15:8] data_value,
                                    // [23:16] control_code, [31:24] data_length
  output logic [1:0]  out_tuser,    // [1:0] kind
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data   // [47:0] expected_address
);

  logic [mfr_pkg::ADDR_W-1:0]     addr_r;
  logic [mfr_pkg::ADDR_BYTES-1:0] mask_r;
  logic                           in_valid_r, in_valid_nxt;
  logic [7:0]                     in_byte_r;
  logic                           has_res;
  logic                           out_free;
  logic                           s1_adv;
  mfr_pkg::result_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      mask_r <= '1;
    end else if (cfg_wr_en) begin
      addr_r <= cfg_wr_data;
      mask_r <= mfr_pkg::compare_mask(cfg_wr_data);
    end
  end

  assign s1_adv    = in_valid_r && (!has_res || out_free);
  assign in_tready = !in_valid_r || s1_adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (s1_adv) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  mfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .rx_byte  (in_byte_r),
    .exp_addr (addr_r),
    .cmp_mask (mask_r),
    .has_res  (has_res),
    .res      (res)
  );

  mfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv && has_res),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `MFR_ASSERT(a_held_byte_stays, clk, rst_n,
    (in_valid_r && !s1_adv) |=> (in_valid_r && $stable(in_byte_r)))
  `MFR_ASSERT(a_mask_follows_addr, clk, rst_n,
    $past(cfg_wr_en) |-> (mask_r == mfr_pkg::compare_mask(addr_r)))

endmodule
